// ===== hw/rtl/tcst_pkg.sv =====
// Shared types, codes and tables for the TCP splice connection state tracker.
package tcst_pkg;

  // Tracking states, as stored in the slot memory
  typedef enum logic [3:0] {
    CS_NONE = 4'd0,
    CS_ES   = 4'd1,
    CS_SS   = 4'd2,
    CS_SR   = 4'd3,
    CS_FW   = 4'd4,
    CS_TW   = 4'd5,
    CS_CL   = 4'd6,
    CS_CW   = 4'd7,
    CS_LA   = 4'd8,
    CS_LI   = 4'd9,
    CS_SA   = 4'd10
  } conn_state_t;

  localparam int NUM_STATES = 11;
  localparam int STATE_W    = 4;
  localparam int IDX_IN_W   = 8;
  localparam int FLAGS_W    = 4;
  localparam int TICK_W     = 28;
  localparam int SCALE_W    = 5;
  localparam int SHAMT_W    = 4;
  localparam int ROW_W      = 3;
  localparam int NUM_ROWS   = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int SCALE_MIN = -8;
  localparam int SCALE_MAX = 8;

  // Opcodes
  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_OPEN    = 1'b1;

  // Flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 3;

  // Row within a direction half of the table
  localparam logic [1:0] ROW_SYN = 2'd0;
  localparam logic [1:0] ROW_FIN = 2'd1;
  localparam logic [1:0] ROW_ACK = 2'd2;
  localparam logic [1:0] ROW_RST = 2'd3;

  // Register index (paddr[2])
  localparam logic REG_TIMEOUT_SCALE = 1'b0;

  // Base timeouts in seconds, by state
  localparam int unsigned BASE_SECONDS [NUM_STATES] = '{
    180, 900, 120, 60, 120, 120, 10, 60, 30, 120, 120
  };

  // Rows: direction*4 + row code; columns: current state
  localparam conn_state_t NEXT_TBL [NUM_ROWS][NUM_STATES] = '{
    '{CS_SR, CS_ES, CS_ES, CS_SR, CS_SR, CS_SR, CS_SR, CS_SR, CS_SR, CS_SR, CS_SR},
    '{CS_CL, CS_CW, CS_SS, CS_TW, CS_TW, CS_TW, CS_CL, CS_CW, CS_LA, CS_LI, CS_TW},
    '{CS_CL, CS_ES, CS_SS, CS_ES, CS_FW, CS_TW, CS_CL, CS_CW, CS_CL, CS_LI, CS_ES},
    '{CS_CL, CS_CL, CS_CL, CS_SR, CS_CL, CS_CL, CS_CL, CS_CL, CS_LA, CS_LI, CS_SR},
    '{CS_SS, CS_ES, CS_SS, CS_SR, CS_SS, CS_SS, CS_SS, CS_SS, CS_SS, CS_LI, CS_SR},
    '{CS_TW, CS_FW, CS_SS, CS_TW, CS_FW, CS_TW, CS_CL, CS_TW, CS_LA, CS_LI, CS_TW},
    '{CS_ES, CS_ES, CS_SS, CS_ES, CS_FW, CS_TW, CS_CL, CS_CW, CS_LA, CS_ES, CS_ES},
    '{CS_CL, CS_CL, CS_SS, CS_CL, CS_CL, CS_TW, CS_CL, CS_CL, CS_CL, CS_CL, CS_CL}
  };

  // Controller states
  typedef enum logic {
    CTRL_IDLE,
    CTRL_UPDATE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture item, start slot read
    logic commit;  // write slot, load result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;  // result register full and not taken
  } dp_status_t;

  // Codes above the last state read as NONE
  function automatic conn_state_t clamp_state(input logic [STATE_W-1:0] raw);
    conn_state_t s;
    if (raw > STATE_W'(CS_SA)) begin
      s = CS_NONE;
    end else begin
      s = conn_state_t'(raw);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/tcst_in_if.sv =====
// Input item channel: valid/ready with segment/open payload.
interface tcst_in_if
  import tcst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [IDX_IN_W-1:0] conn_index;
  logic                direction;
  logic                is_tcp;
  logic [FLAGS_W-1:0]  tcp_flags;
  logic                both_established;

  modport source (output valid, opcode, conn_index, direction, is_tcp, tcp_flags,
                  both_established, input ready);
  modport sink (input valid, opcode, conn_index, direction, is_tcp, tcp_flags,
                both_established, output ready);
endinterface

// ===== hw/rtl/tcst_out_if.sv =====
// Result channel: valid/ready with new state, timeout and status.
interface tcst_out_if
  import tcst_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] track_state;
  logic [TICK_W-1:0]  timeout_ticks;
  logic               status;

  modport source (output valid, track_state, timeout_ticks, status, input ready);
  modport sink (input valid, track_state, timeout_ticks, status, output ready);
endinterface

// ===== hw/rtl/tcst_cfg_regs.sv =====
// APB-style configuration register block holding timeout_scale.
module tcst_cfg_regs
  import tcst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  output logic signed [SCALE_W-1:0]    timeout_scale
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_scale <= '0;
    end else if (wr_en) begin
      timeout_scale <= pwdata[SCALE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT_SCALE) begin
      prdata = {{(APB_DATA_W-SCALE_W){1'b0}}, timeout_scale};
    end
  end

endmodule

// ===== hw/rtl/tcst_ctrl.sv =====
// Controller FSM: accepts one item, then commits it when the result register is free.
module tcst_ctrl
  import tcst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_IDLE: begin
        if (in_valid) state_next = CTRL_UPDATE;
      end
      CTRL_UPDATE: begin
        if (!stat.out_stall) state_next = CTRL_IDLE;
      end
      default: state_next = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      CTRL_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      CTRL_UPDATE: begin
        cmd.commit = !stat.out_stall;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/tcst_datapath.sv =====
// Datapath: slot memory, next-state lookup, timeout scaling and result register.
module tcst_datapath
  import tcst_pkg::*;
#(
  parameter int CONN_SLOTS       = 256,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                stat,
  input  logic                      opcode,
  input  logic [IDX_IN_W-1:0]       conn_index,
  input  logic                      direction,
  input  logic                      is_tcp,
  input  logic [FLAGS_W-1:0]        tcp_flags,
  input  logic                      both_established,
  input  logic signed [SCALE_W-1:0] timeout_scale,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATE_W-1:0]        track_state,
  output logic [TICK_W-1:0]         timeout_ticks,
  output logic                      status
);

  localparam int IDX_W     = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
  localparam int IN_VALUES = 1 << IDX_IN_W;

  // conn_index modulo slot count, as a constant table
  logic [IDX_W-1:0]  slot_lut [IN_VALUES];
  logic [TICK_W-1:0] base_lut [NUM_STATES];

  for (genvar g = 0; g < IN_VALUES; g++) begin : g_slot
    assign slot_lut[g] = IDX_W'(g % CONN_SLOTS);
  end
  for (genvar g = 0; g < NUM_STATES; g++) begin : g_base
    assign base_lut[g] = TICK_W'(BASE_SECONDS[g] * TICKS_PER_SECOND);
  end

  logic [STATE_W-1:0] mem [CONN_SLOTS];
  logic [STATE_W-1:0] rd_data;

  logic               op_r;
  logic [IDX_W-1:0]   slot_r;
  logic               dir_r;
  logic               tcp_r;
  logic [FLAGS_W-1:0] flags_r;
  logic               both_r;

  conn_state_t               cur;
  conn_state_t               nxt;
  logic [1:0]                row;
  logic                      row_hit;
  logic                      err;
  logic signed [SCALE_W-1:0] sc;
  logic signed [SCALE_W-1:0] sc_neg;
  logic [SHAMT_W-1:0]        shamt;
  logic [TICK_W-1:0]         ticks;

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= mem[slot_lut[conn_index]];
    end
    if (cmd.commit && !err) begin
      mem[slot_r] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode;
      slot_r  <= slot_lut[conn_index];
      dir_r   <= direction;
      tcp_r   <= is_tcp;
      flags_r <= tcp_flags;
      both_r  <= both_established;
    end
  end

  // flag priority: rst, syn, fin, ack
  always_comb begin
    row     = ROW_SYN;
    row_hit = 1'b1;
    priority if (flags_r[FLAG_RST]) row = ROW_RST;
    else if (flags_r[FLAG_SYN]) row = ROW_SYN;
    else if (flags_r[FLAG_FIN]) row = ROW_FIN;
    else if (flags_r[FLAG_ACK]) row = ROW_ACK;
    else row_hit = 1'b0;
  end

  assign cur = clamp_state(rd_data);
  assign err = (op_r == OP_SEGMENT) && !tcp_r;

  always_comb begin
    if (op_r == OP_OPEN) begin
      nxt = both_r ? CS_ES : CS_NONE;
    end else if (!row_hit) begin
      nxt = CS_CL;
    end else begin
      nxt = NEXT_TBL[{dir_r, row}][cur];
    end
  end

  // saturate scale, then shift the base timeout either way
  always_comb begin
    if (timeout_scale < SCALE_MIN) begin
      sc = SCALE_W'(SCALE_MIN);
    end else if (timeout_scale > SCALE_MAX) begin
      sc = SCALE_W'(SCALE_MAX);
    end else begin
      sc = timeout_scale;
    end
    sc_neg = -sc;
    if (sc < 0) begin
      shamt = sc_neg[SHAMT_W-1:0];
      ticks = base_lut[nxt] >> shamt;
    end else begin
      shamt = sc[SHAMT_W-1:0];
      ticks = base_lut[nxt] << shamt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      track_state   <= err ? cur : nxt;
      timeout_ticks <= err ? '0 : ticks;
      status        <= err;
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

endmodule

// ===== hw/rtl/tcp_splice_conn_state_tracker_unit.sv =====
// Top level: TCP splice connection state tracker.
// An input transfer captures the item and registers its slot read; the update state then
// writes the slot and loads the result register, waiting while that register is stalled.
// A new item is taken only once the update for the last one is done.
// Reset (rst, synchronous, active high) clears the FSM, result valid and timeout_scale;
// the slot memory is not cleared, a slot holds its state only once written.
module tcp_splice_conn_state_tracker_unit
  import tcst_pkg::*;
#(
  parameter int CONN_SLOTS       = 256,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic                  clk,
  input  logic                  rst,
  tcst_in_if.sink               seg_in,
  tcst_out_if.source            res_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_cmd_t                 cmd;
  dp_status_t                stat;
  logic signed [SCALE_W-1:0] timeout_scale;

  // timeout_scale register at byte address 0
  tcst_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .timeout_scale(timeout_scale)
  );

  // Idle takes a transfer; update waits only while the result register is stalled.
  // A new item can be taken while a finished result still waits downstream.
  tcst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(seg_in.valid),
    .in_ready(seg_in.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Slot read on load; next-state, timeout and slot write on commit.
  // Non-TCP segments leave the slot untouched and report status 1.
  tcst_datapath #(
    .CONN_SLOTS      (CONN_SLOTS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (seg_in.opcode),
    .conn_index      (seg_in.conn_index),
    .direction       (seg_in.direction),
    .is_tcp          (seg_in.is_tcp),
    .tcp_flags       (seg_in.tcp_flags),
    .both_established(seg_in.both_established),
    .timeout_scale   (timeout_scale),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .track_state     (res_out.track_state),
    .timeout_ticks   (res_out.timeout_ticks),
    .status          (res_out.status)
  );

endmodule

// ===== hw/rtl/tcst_checker.sv =====
// Port-level checker for the tracker, bound to the top level.
module tcst_checker
  import tcst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               seg_valid,
  input logic               seg_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [STATE_W-1:0] track_state,
  input logic [TICK_W-1:0]  timeout_ticks,
  input logic               status
);

  // one item in flight: no transfer in the cycle right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_ready) |=> !seg_ready)
    else $error("input ready right after a transfer");

  // with the result register free after the slot read, the update loads a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_ready) ##1 (!res_valid || res_ready) |=> res_valid)
    else $error("result missing after input transfer");

  // error results carry no timeout
  a_err_timeout: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status) |-> (timeout_ticks == '0))
    else $error("non-TCP result with nonzero timeout");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (track_state <= STATE_W'(CS_SA)))
    else $error("result state code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(track_state) &&
      $stable(timeout_ticks) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind tcp_splice_conn_state_tracker_unit tcst_checker u_tcst_checker (
  .clk          (clk),
  .rst          (rst),
  .seg_valid    (seg_in.valid),
  .seg_ready    (seg_in.ready),
  .res_valid    (res_out.valid),
  .res_ready    (res_out.ready),
  .track_state  (res_out.track_state),
  .timeout_ticks(res_out.timeout_ticks),
  .status       (res_out.status)
);
